[hw/rtl/pud_pkg.sv]
// Shared types, codes and helper functions for the percent/URL decoder.
// No dependencies; pud_decode, pud_result_buf and percent_url_decoder import this package.
`timescale 1ns / 1ps

package pud_pkg;

	localparam int MAX_RES = 4;
	localparam int CNT_W   = $clog2(MAX_RES + 1);
	localparam int IDX_W   = $clog2(MAX_RES);

	// error codes carried on the result word
	localparam logic [2:0] ERR_OK         = 3'd0;
	localparam logic [2:0] ERR_UNACCEPTED = 3'd1;
	localparam logic [2:0] ERR_INCOMPLETE = 3'd2;
	localparam logic [2:0] ERR_BAD_HEX    = 3'd3;
	localparam logic [2:0] ERR_BAD_LOW    = 3'd4;

	// escape position codes
	localparam logic [3:0] POS_IDLE = 4'd0;   // outside any escape
	localparam logic [3:0] POS_PCT  = 4'd1;   // after '%'
	localparam logic [3:0] POS_HEX2 = 4'd2;   // after first digit of %XX
	localparam logic [3:0] POS_U0   = 4'd3;   // after %u
	localparam logic [3:0] POS_U1   = 4'd4;
	localparam logic [3:0] POS_U2   = 4'd5;
	localparam logic [3:0] POS_U3   = 4'd6;   // three unit digits in
	localparam logic [3:0] POS_L0   = 4'd7;   // low surrogate expected
	localparam logic [3:0] POS_L1   = 4'd8;
	localparam logic [3:0] POS_L2   = 4'd9;
	localparam logic [3:0] POS_L3   = 4'd10;

	typedef struct packed {
		logic [3:0]  pos;
		logic [15:0] high;
		logic [15:0] low;
		logic        drop;
	} pud_state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] error_code;
		logic       run_last;
		logic       message_end;
	} pud_result_t;

	// all result words produced by one input byte
	typedef struct packed {
		logic [CNT_W-1:0]                  cnt;
		pud_result_t [MAX_RES-1:0]         res;
	} pud_group_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} pud_hex_t;

	typedef struct packed {
		logic [CNT_W-1:0]       n;
		logic [MAX_RES-1:0][7:0] b;
	} pud_utf8_t;

	function automatic pud_hex_t hex_value(input logic [7:0] b);
		pud_hex_t h;
		h.ok  = 1'b0;
		h.val = 4'd0;
		if (b inside {["0":"9"]}) begin
			h.ok  = 1'b1;
			h.val = b[3:0];
		end else if (b inside {["a":"f"], ["A":"F"]}) begin
			h.ok  = 1'b1;
			h.val = b[3:0] + 4'd9;
		end
		return h;
	endfunction

	function automatic logic char_accepted(input logic [7:0] b, input logic uri_set);
		logic ok;
		ok = b inside {["0":"9"], ["a":"z"], ["A":"Z"]};
		if (uri_set) begin
			ok = ok || (b inside {"-", "_", ".", "!", "~", "*", "'", "(", ")", ";", "/",
				"?", ":", "@", "&", "=", "+", "$", ",", "#"});
		end else begin
			ok = ok || (b inside {".", "-", "~", "_"});
		end
		return ok;
	endfunction

	function automatic pud_utf8_t utf8_encode(input logic [20:0] cp);
		pud_utf8_t e;
		e = '0;
		if (cp <= 21'h00007F) begin
			e.n    = CNT_W'(1);
			e.b[0] = cp[7:0];
		end else if (cp <= 21'h0007FF) begin
			e.n    = CNT_W'(2);
			e.b[0] = {3'b110, cp[10:6]};
			e.b[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'h00FFFF) begin
			e.n    = CNT_W'(3);
			e.b[0] = {4'b1110, cp[15:12]};
			e.b[1] = {2'b10, cp[11:6]};
			e.b[2] = {2'b10, cp[5:0]};
		end else begin
			e.n    = CNT_W'(4);
			e.b[0] = {5'b11110, cp[20:18]};
			e.b[1] = {2'b10, cp[17:12]};
			e.b[2] = {2'b10, cp[11:6]};
			e.b[3] = {2'b10, cp[5:0]};
		end
		return e;
	endfunction

endpackage

[hw/rtl/pud_in_if.sv]
// Input channel: one escaped byte per word with an end-of-string flag.
// Standalone valid/ready interface, no dependencies.
`timescale 1ns / 1ps

interface pud_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[hw/rtl/pud_out_if.sv]
// Output channel: one decoded byte or error report per word.
// Standalone valid/ready interface, no dependencies.
`timescale 1ns / 1ps

interface pud_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [2:0] error_code;
	logic       run_last;
	logic       message_end;

	modport source (output valid, output out_byte, output error_code, output run_last,
		output message_end, input ready);
	modport sink   (input valid, input out_byte, input error_code, input run_last,
		input message_end, output ready);
endinterface

[hw/rtl/pud_decode.sv]
// Per-byte decode step: next escape state and the result words one byte produces.
// Purely combinational; uses pud_pkg.
`timescale 1ns / 1ps

module pud_decode (
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	input  logic                uri_set,
	input  pud_pkg::pud_state_t st,
	output pud_pkg::pud_state_t nxt,
	output pud_pkg::pud_group_t grp
);
	import pud_pkg::*;

	pud_hex_t         hv;
	logic             fail;
	logic [2:0]       fcode;
	logic             use_enc;
	logic [20:0]      cp;
	logic [15:0]      unit;
	logic [15:0]      lw;
	pud_utf8_t        enc;
	logic [CNT_W-1:0] cnt;

	assign hv   = hex_value(in_byte);
	assign unit = {st.high[11:0], hv.val};
	assign lw   = {st.low[11:0], hv.val};
	assign enc  = utf8_encode(cp);

	always_comb begin
		nxt     = st;
		fail    = 1'b0;
		fcode   = ERR_OK;
		use_enc = 1'b0;
		cp      = '0;
		cnt     = '0;
		grp     = '0;

		if (st.drop) begin
			if (in_last) nxt.drop = 1'b0;
		end else begin
			case (st.pos)
				POS_IDLE: begin
					if (in_byte == "%") begin
						if (in_last) begin
							fail  = 1'b1;
							fcode = ERR_INCOMPLETE;
						end else begin
							nxt.pos  = POS_PCT;
							nxt.high = '0;
							nxt.low  = '0;
						end
					end else if (char_accepted(in_byte, uri_set)) begin
						cnt                = CNT_W'(1);
						grp.res[0].out_byte = in_byte;
					end else begin
						fail  = 1'b1;
						fcode = ERR_UNACCEPTED;
					end
				end
				POS_PCT: begin
					if (in_byte == "u" || in_byte == "U") begin
						if (in_last) begin
							fail  = 1'b1;
							fcode = ERR_INCOMPLETE;
						end else begin
							nxt.pos = POS_U0;
						end
					end else if (!hv.ok) begin
						fail  = 1'b1;
						fcode = ERR_BAD_HEX;
					end else if (in_last) begin
						fail  = 1'b1;
						fcode = ERR_INCOMPLETE;
					end else begin
						nxt.high = {12'd0, hv.val};
						nxt.pos  = POS_HEX2;
					end
				end
				POS_HEX2: begin
					if (!hv.ok) begin
						fail  = 1'b1;
						fcode = ERR_BAD_HEX;
					end else begin
						cnt                 = CNT_W'(1);
						grp.res[0].out_byte = {st.high[3:0], hv.val};
						nxt.pos             = POS_IDLE;
						nxt.high            = '0;
					end
				end
				POS_U0, POS_U1, POS_U2, POS_U3: begin
					if (!hv.ok) begin
						fail  = 1'b1;
						fcode = ERR_BAD_HEX;
					end else begin
						nxt.high = unit;
						if (st.pos != POS_U3) begin
							if (in_last) begin
								fail  = 1'b1;
								fcode = ERR_INCOMPLETE;
							end else begin
								nxt.pos = st.pos + 4'd1;
							end
						end else if (unit[15:10] == 6'b110110) begin
							// high surrogate: low unit must follow directly
							if (in_last) begin
								fail  = 1'b1;
								fcode = ERR_INCOMPLETE;
							end else begin
								nxt.pos = POS_L0;
								nxt.low = '0;
							end
						end else begin
							nxt.pos  = POS_IDLE;
							nxt.high = '0;
							use_enc  = 1'b1;
							cp       = {5'd0, unit};
						end
					end
				end
				POS_L0, POS_L1, POS_L2, POS_L3: begin
					if (!hv.ok) begin
						fail  = 1'b1;
						fcode = ERR_BAD_HEX;
					end else begin
						nxt.low = lw;
						if (st.pos != POS_L3) begin
							if (in_last) begin
								fail  = 1'b1;
								fcode = ERR_INCOMPLETE;
							end else begin
								nxt.pos = st.pos + 4'd1;
							end
						end else if (lw[15:10] != 6'b110111) begin
							fail  = 1'b1;
							fcode = ERR_BAD_LOW;
						end else begin
							nxt.pos  = POS_IDLE;
							nxt.high = '0;
							nxt.low  = '0;
							use_enc  = 1'b1;
							cp       = 21'h010000 + {1'b0, st.high[9:0], lw[9:0]};
						end
					end
				end
				default: begin
					nxt.pos = POS_IDLE;
				end
			endcase

			if (use_enc) begin
				cnt = enc.n;
				for (int k = 0; k < MAX_RES; k++) grp.res[k].out_byte = enc.b[k];
			end

			if (fail) begin
				cnt                   = CNT_W'(1);
				grp.res[0].out_byte   = 8'd0;
				grp.res[0].error_code = fcode;
				nxt.pos               = POS_IDLE;
				nxt.high              = '0;
				nxt.low               = '0;
				nxt.drop              = !in_last;
			end
		end

		for (int k = 0; k < MAX_RES; k++) begin
			grp.res[k].run_last    = (cnt == CNT_W'(k + 1));
			grp.res[k].message_end = in_last && (cnt == CNT_W'(k + 1));
		end
		grp.cnt = cnt;

		if (in_last && cnt != '0 && !nxt.drop) begin
			nxt.pos  = POS_IDLE;
			nxt.high = '0;
			nxt.low  = '0;
		end
	end

endmodule

[hw/rtl/pud_result_buf.sv]
// Result register: holds the words of one decoded byte and hands them out one a cycle while the sink is ready.
// Uses pud_pkg and the pud_out_if channel.
`timescale 1ns / 1ps

module pud_result_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  pud_pkg::pud_group_t grp,
	output logic                can_load,
	pud_out_if.source           decoded
);
	import pud_pkg::*;

	pud_result_t [MAX_RES-1:0] res_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [IDX_W-1:0]          idx_q;
	pud_result_t               cur;
	logic                      take;

	assign cur      = res_q[idx_q];
	assign take     = decoded.valid && decoded.ready;
	// free once the final word of the group leaves
	assign can_load = (cnt_q == '0) || (take && cur.run_last);

	assign decoded.valid       = (cnt_q != '0);
	assign decoded.out_byte    = cur.out_byte;
	assign decoded.error_code  = cur.error_code;
	assign decoded.run_last    = cur.run_last;
	assign decoded.message_end = cur.message_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= grp.cnt;
			idx_q <= '0;
		end else if (take) begin
			if (cur.run_last) cnt_q <= '0;
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= grp.res;
	end

endmodule

[hw/rtl/percent_url_decoder.sv]
// Percent/UTF-16 escape decoder: one escaped byte in, 0 to 4 result words out.
// Input bytes are registered in stage s1, decoded combinationally and loaded into the result register.
// Throughput: one input byte per cycle while the result register can take its words; a byte
// yielding n words holds the result register until all n leave the single-word output port.
// Reset (arst_n low): escape state, drop flag, charset select and both stages cleared.
`timescale 1ns / 1ps

module percent_url_decoder (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      charset_we,
	input  logic      charset_wdata,
	pud_in_if.sink    escaped,
	pud_out_if.source decoded
);
	import pud_pkg::*;

	logic       valid_s1;
	logic [7:0] in_byte_s1;
	logic       in_last_s1;
	logic       charset_q;
	pud_state_t st_q;
	pud_state_t nxt;
	pud_group_t grp;
	logic       can_load;
	logic       adv_s1;
	logic       load;

	// a byte with no result words never waits for the result register
	assign adv_s1        = valid_s1 && (grp.cnt == '0 || can_load);
	assign load          = valid_s1 && grp.cnt != '0 && can_load;
	assign escaped.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			charset_q <= 1'b0;
			st_q      <= '0;
		end else begin
			if (charset_we) charset_q <= charset_wdata;
			if (escaped.valid && escaped.ready) valid_s1 <= 1'b1;
			else if (adv_s1) valid_s1 <= 1'b0;
			if (adv_s1) st_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (escaped.valid && escaped.ready) begin
			in_byte_s1 <= escaped.in_byte;
			in_last_s1 <= escaped.in_last;
		end
	end

	pud_decode u_decode (
		.in_byte (in_byte_s1),
		.in_last (in_last_s1),
		.uri_set (charset_q),
		.st      (st_q),
		.nxt     (nxt),
		.grp     (grp)
	);

	pud_result_buf u_result_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.grp      (grp),
		.can_load (can_load),
		.decoded  (decoded)
	);

endmodule

[hw/rtl/pud_checker.sv]
// Port-level checks on the decoder's result channel, bound to percent_url_decoder.
// Sees top-level ports only; no package dependency.
`timescale 1ns / 1ps

module pud_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [2:0] error_code,
	input logic       run_last,
	input logic       message_end
);

	// a stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word withdrawn while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != 3'd0 |-> out_byte == 8'd0 && run_last)
		else $error("error word must be a lone zero byte");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_end |-> run_last)
		else $error("string end not on last word of its byte");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code <= 3'd4)
		else $error("error code out of range");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result offered straight after reset");

endmodule

bind percent_url_decoder pud_checker u_pud_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (decoded.valid),
	.out_ready   (decoded.ready),
	.out_byte    (decoded.out_byte),
	.error_code  (decoded.error_code),
	.run_last    (decoded.run_last),
	.message_end (decoded.message_end)
);
